>>> rtl/fpa_pkg.sv
// shared types and constants for the q24.8 fixed-point alu
// no dependencies
package fpa_pkg;

    localparam int FRAC_BITS  = 8;
    localparam int DATA_W     = 32;
    localparam int NUM_W      = DATA_W + FRAC_BITS;
    localparam int DIV_STEPS  = (NUM_W + 1) / 2;
    localparam int PAD_W      = 2 * DIV_STEPS;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int PIPE_DEPTH = DIV_STEPS + 3;

    typedef enum logic [3:0] {
        CMD_ADD      = 4'd0,
        CMD_SUB      = 4'd1,
        CMD_MUL      = 4'd2,
        CMD_DIV      = 4'd3,
        CMD_EQ       = 4'd4,
        CMD_NE       = 4'd5,
        CMD_GT       = 4'd6,
        CMD_GE       = 4'd7,
        CMD_LE       = 4'd8,
        CMD_LT       = 4'd9,
        CMD_MIN      = 4'd10,
        CMD_MAX      = 4'd11,
        CMD_INC      = 4'd12,
        CMD_DEC      = 4'd13,
        CMD_FROM_INT = 4'd14,
        CMD_TO_INT   = 4'd15
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OVF  = 2'd1,
        ST_DIV0 = 2'd2
    } t_status;

    typedef struct packed {
        logic               vld;
        t_cmd               cmd;
        logic [DATA_W-1:0]  res;
        logic               cmp;
        t_status            status;
        logic               neg;
        logic [DATA_W-1:0]  ma;
        logic [DATA_W-1:0]  mb;
        logic [PAD_W-1:0]   num;
        logic [PAD_W-1:0]   quo;
        logic [DATA_W-1:0]  rem;
        logic [PROD_W-1:0]  prod;
        logic [DATA_W:0]    mag;
        logic               ovf;
    } t_stage;

endpackage

>>> rtl/fixed_point_alu_q24_8_core.sv
// Every command passes through the whole pipeline, and one item is accepted per cycle while
// the output is not stalled. The depth is set by the divider, which resolves two quotient bits per
// stage over 40 bits; the 32x32 multiply sits in one stage, rounding and saturation take the
// last two. Items leave in order; a stall at the output holds the whole pipeline.
// depends on fpa_pkg
module fixed_point_alu_q24_8_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [3:0]                 i_command,
    input  logic signed [fpa_pkg::DATA_W-1:0] i_operand_a,
    input  logic signed [fpa_pkg::DATA_W-1:0] i_operand_b,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [fpa_pkg::DATA_W-1:0] o_result,
    output logic                       o_compare_true,
    output logic [1:0]                 o_status
);
    import fpa_pkg::*;

    t_stage r_pipe [PIPE_DEPTH];
    t_stage n_pipe [PIPE_DEPTH];
    logic   en;

    // two restoring division steps
    function automatic t_stage div_step(input t_stage s);
        t_stage           o;
        logic [DATA_W:0]  sh;
        o = s;
        for (int j = 0; j < 2; j++) begin
            sh = {o.rem, o.num[PAD_W-1]};
            o.num = {o.num[PAD_W-2:0], 1'b0};
            if (sh >= {1'b0, o.mb}) begin
                o.rem = DATA_W'(sh - {1'b0, o.mb});
                o.quo = {o.quo[PAD_W-2:0], 1'b1};
            end else begin
                o.rem = sh[DATA_W-1:0];
                o.quo = {o.quo[PAD_W-2:0], 1'b0};
            end
        end
        return o;
    endfunction

    assign en      = !(r_pipe[PIPE_DEPTH-1].vld && i_stall);
    assign o_stall = !en;

    always_comb begin
        t_cmd               c;
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
        t_stage             s;
        t_stage             last;
        c = t_cmd'(i_command);
        a = i_operand_a;
        b = i_operand_b;

        // entry stage: all commands but multiply and divide get their result here
        s        = '0;
        s.vld    = i_valid;
        s.cmd    = c;
        s.neg    = a[DATA_W-1] ^ b[DATA_W-1];
        s.ma     = a[DATA_W-1] ? DATA_W'(-a) : a;
        s.mb     = b[DATA_W-1] ? DATA_W'(-b) : b;
        s.num    = PAD_W'({s.ma, {FRAC_BITS{1'b0}}});
        s.status = ST_OK;
        case (c)
            CMD_ADD:      s.res = a + b;
            CMD_SUB:      s.res = a - b;
            CMD_DIV:      if (b == '0) s.status = ST_DIV0;
            CMD_EQ:       s.cmp = (a == b);
            CMD_NE:       s.cmp = (a != b);
            CMD_GT:       s.cmp = (a > b);
            CMD_GE:       s.cmp = (a >= b);
            CMD_LE:       s.cmp = (a <= b);
            CMD_LT:       s.cmp = (a < b);
            CMD_MIN:      s.res = (a < b) ? a : b;
            CMD_MAX:      s.res = (a > b) ? a : b;
            CMD_INC:      s.res = a + DATA_W'(1);
            CMD_DEC:      s.res = a - DATA_W'(1);
            CMD_FROM_INT: s.res = a <<< FRAC_BITS;
            CMD_TO_INT:   s.res = a >>> FRAC_BITS;
            default:      s.res = '0;
        endcase
        n_pipe[0] = s;

        for (int k = 1; k <= DIV_STEPS; k++) begin
            n_pipe[k] = div_step(r_pipe[k-1]);
        end
        n_pipe[1].prod = r_pipe[0].ma * r_pipe[0].mb;

        // rounded magnitude, half away from zero
        s = r_pipe[DIV_STEPS];
        if (s.cmd == CMD_MUL) begin
            s.ovf = |s.prod[PROD_W-1:FRAC_BITS+DATA_W];
            s.mag = {1'b0, s.prod[FRAC_BITS+DATA_W-1:FRAC_BITS]}
                  + (DATA_W+1)'(s.prod[FRAC_BITS-1]);
        end else begin
            s.ovf = |s.quo[PAD_W-1:DATA_W];
            s.mag = {1'b0, s.quo[DATA_W-1:0]}
                  + (DATA_W+1)'({s.rem, 1'b0} >= {1'b0, s.mb});
        end
        n_pipe[DIV_STEPS+1] = s;

        // sign and saturation
        s = r_pipe[DIV_STEPS+1];
        if ((s.cmd == CMD_MUL || s.cmd == CMD_DIV) && s.status != ST_DIV0) begin
            if (s.neg) begin
                if (s.ovf || s.mag[DATA_W] || (s.mag[DATA_W-1] && |s.mag[DATA_W-2:0])) begin
                    s.res    = {1'b1, {(DATA_W-1){1'b0}}};
                    s.status = ST_OVF;
                end else begin
                    s.res = DATA_W'(-s.mag);
                end
            end else begin
                if (s.ovf || s.mag[DATA_W] || s.mag[DATA_W-1]) begin
                    s.res    = {1'b0, {(DATA_W-1){1'b1}}};
                    s.status = ST_OVF;
                end else begin
                    s.res = s.mag[DATA_W-1:0];
                end
            end
        end
        last = s;
        n_pipe[PIPE_DEPTH-1] = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PIPE_DEPTH; k++) r_pipe[k].vld <= 1'b0;
        end else if (en) begin
            r_pipe <= n_pipe;
        end
    end

    assign o_valid        = r_pipe[PIPE_DEPTH-1].vld;
    assign o_result       = r_pipe[PIPE_DEPTH-1].res;
    assign o_compare_true = r_pipe[PIPE_DEPTH-1].cmp;
    assign o_status       = r_pipe[PIPE_DEPTH-1].status;

endmodule

>>> rtl/fpa_checker.sv
// port-level checks for the fixed-point alu, bound to the top level
// depends on fpa_pkg and fixed_point_alu_q24_8_core
module fpa_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_valid,
    input logic                       i_stall,
    input logic [fpa_pkg::DATA_W-1:0] o_result,
    input logic                       o_compare_true,
    input logic [1:0]                 o_status
);
    import fpa_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result) && $stable(o_status))
        else $error("stalled item changed");

    a_div0_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_DIV0 |-> o_result == '0 && !o_compare_true)
        else $error("divide by zero item not cleared");

    a_cmp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_compare_true |-> o_result == '0 && o_status == ST_OK)
        else $error("comparison item carries data");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status != 2'd3)
        else $error("undefined status code");

endmodule

bind fixed_point_alu_q24_8_core fpa_checker u_fpa_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_result       (o_result),
    .o_compare_true (o_compare_true),
    .o_status       (o_status)
);

>>> tb/tb_top.sv
// testbench for the q24.8 fixed-point alu: directed and random commands,
// results checked in order against a behavioral predictor; depends on fpa_pkg
`timescale 1ns / 1ps

module tb_top;
    import fpa_pkg::*;

    typedef struct {
        logic [31:0] res;
        logic        cmp;
        logic [1:0]  status;
    } t_alu_out;

    class alu_scoreboard;
        t_alu_out pending[$];
        int       errors;
        int       checked;

        function void note_item(t_cmd cmd, logic [31:0] a, logic [31:0] b);
            pending.push_back(predict_alu(cmd, a, b));
        endfunction

        function void check_result(logic [31:0] res, logic cmp, logic [1:0] status);
            t_alu_out e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result res=%h cmp=%0d st=%0d",
                         $time, res, cmp, status);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (e.res !== res || e.cmp !== cmp || e.status !== status) begin
                $display("%0t: mismatch expected res=%h cmp=%0d st=%0d %s",
                         $time, e.res, e.cmp, e.status, "actual");
                $display("%0t:          actual   res=%h cmp=%0d st=%0d",
                         $time, res, cmp, status);
                errors++;
            end
        endfunction
    endclass

    // saturate a signed magnitude to 32 bits
    function automatic logic [31:0] clamp_mag(logic [63:0] m, logic neg, ref logic [1:0] st);
        if (neg) begin
            if (m > 64'd2147483648) begin
                st = ST_OVF;
                return 32'h8000_0000;
            end
            return 32'(-m);
        end
        if (m > 64'd2147483647) begin
            st = ST_OVF;
            return 32'h7fff_ffff;
        end
        return m[31:0];
    endfunction

    function automatic t_alu_out predict_alu(t_cmd cmd, logic [31:0] a, logic [31:0] b);
        t_alu_out o;
        logic signed [31:0] sa, sb;
        logic [63:0] ma, mb, p, q, r, num;
        logic [1:0] st;
        sa = a;
        sb = b;
        ma = sa < 0 ? 64'(-64'(sa)) : 64'(sa);
        mb = sb < 0 ? 64'(-64'(sb)) : 64'(sb);
        st = ST_OK;
        o.res = '0;
        o.cmp = 1'b0;
        case (cmd)
            CMD_ADD:  o.res = a + b;
            CMD_SUB:  o.res = a - b;
            CMD_MUL: begin
                p = ma * mb;
                q = (p >> FRAC_BITS) + (p[FRAC_BITS-1] ? 64'd1 : 64'd0);
                o.res = clamp_mag(q, (sa < 0) != (sb < 0), st);
            end
            CMD_DIV: begin
                if (b == 0) st = ST_DIV0;
                else begin
                    num = ma << FRAC_BITS;
                    q = num / mb;
                    r = num % mb;
                    if (2 * r >= mb) q++;
                    o.res = clamp_mag(q, (sa < 0) != (sb < 0), st);
                end
            end
            CMD_EQ:   o.cmp = sa == sb;
            CMD_NE:   o.cmp = sa != sb;
            CMD_GT:   o.cmp = sa > sb;
            CMD_GE:   o.cmp = sa >= sb;
            CMD_LE:   o.cmp = sa <= sb;
            CMD_LT:   o.cmp = sa < sb;
            CMD_MIN:  o.res = (sa < sb) ? a : b;
            CMD_MAX:  o.res = (sa > sb) ? a : b;
            CMD_INC:  o.res = a + 1;
            CMD_DEC:  o.res = a - 1;
            CMD_FROM_INT: o.res = a << FRAC_BITS;
            default:  o.res = sa >>> FRAC_BITS;
        endcase
        o.status = st;
        return o;
    endfunction

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_stall;
    logic [3:0]  i_command = '0;
    logic signed [31:0] i_operand_a = '0;
    logic signed [31:0] i_operand_b = '0;
    logic        o_valid;
    logic        i_stall = 0;
    logic signed [31:0] o_result;
    logic        o_compare_true;
    logic [1:0]  o_status;

    alu_scoreboard sb = new();
    bit calm = 0;
    bit done_in = 0;
    int n_sent = 0;

    always #2 i_clk = ~i_clk;

    fixed_point_alu_q24_8_core DUT (.*);

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000 + $urandom_range(0, 3);
            1: return 32'h7fff_ffff - $urandom_range(0, 3);
            2: return 32'($signed($urandom_range(0, 4096)) - 2048);
            3: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return $urandom();
        endcase
    endfunction

    // one item, held until accepted, with random idle cycles before it while calm is clear
    task automatic send_item(t_cmd cmd, logic [31:0] a, logic [31:0] b);
        while (!calm && $urandom_range(0, 99) < 17) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_command   <= cmd;
        i_operand_a <= a;
        i_operand_b <= b;
        do @(posedge i_clk); while (o_stall);
        sb.note_item(cmd, a, b);
        n_sent++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_result, o_compare_true, o_status);
        i_stall <= !calm && ($urandom_range(0, 99) < 17);
    end

    initial begin
        logic [31:0] ext[6] = '{32'h0, 32'h1, 32'hffff_ffff, 32'h7fff_ffff,
                                32'h8000_0000, 32'h100};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // each command on edge operands, then the divide-by-zero, rounding, overflow and tie corners
        for (int c = 0; c < 16; c++)
            send_item(t_cmd'(c), ext[c % 6], ext[(c + 3) % 6]);
        send_item(CMD_DIV, 32'h100, 32'h0);
        send_item(CMD_DIV, 32'h7fff_ffff, 32'h1);
        send_item(CMD_MUL, 32'h8000_0000, 32'hffff_ff00);
        send_item(CMD_MUL, 32'h180, 32'h1);
        send_item(CMD_MUL, 32'hffff_fe80, 32'h1);
        send_item(CMD_MIN, 32'h55, 32'h55);
        send_item(CMD_MAX, 32'h8000_0000, 32'h8000_0000);
        send_item(CMD_TO_INT, 32'hffff_ff01, 32'h0);
        send_item(CMD_DIV, 32'h8000_0000, 32'hffff_ffff);
        for (int i = 0; i < 400; i++) begin
            calm = (i >= 150 && i < 230);
            send_item(t_cmd'($urandom_range(0, 15)), rand_operand(),
                      ($urandom_range(0, 15) == 0) ? 32'h0 : rand_operand());
        end
        i_valid <= 1'b0;
        done_in = 1;
    end

    initial begin
        wait (done_in);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 10) @(posedge i_clk);
        $display("sent %0d items over all 16 commands, %0d results checked",
                 n_sent, sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #400000;
        $display("timeout");
        $display("FAIL");
        $finish;
    end
endmodule
